/* sv/varint_record_field_parser_assert.svh */
// ----------------------------------------------------------------------------
// varint record field parser assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef VARINT_RECORD_FIELD_PARSER_ASSERT_SVH
`define VARINT_RECORD_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define VRFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrfp assertion failed");

// next-cycle implication
`define VRFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrfp assertion failed");

`endif

/* sv/vrfp_pkg.sv */
// ----------------------------------------------------------------------------
// vrfp_pkg
// types and constants of the varint record field parser
// ----------------------------------------------------------------------------
`default_nettype none

package vrfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } vrfp_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] magic;
    logic [63:0] kind;
    logic [63:0] header_version;
    logic [63:0] frames_per_second;
    logic [63:0] frame_width;
    logic [63:0] frame_height;
    logic [63:0] frame_count;
  } vrfp_out_t;

  // classified request between front and back
  typedef struct packed {
    vrfp_in_t req;
    logic     size_bad;
  } vrfp_mid_t;

  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_VALUE  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_SKIP   = 2'd3
  } vrfp_phase_t;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_KEY_BAD   = 4'd1;
  localparam logic [3:0] ST_FIELD_BAD = 4'd2;
  localparam logic [3:0] ST_DESC_WIRE = 4'd3;
  localparam logic [3:0] ST_DESC_LEN  = 4'd4;
  localparam logic [3:0] ST_NUM_WIRE  = 4'd5;
  localparam logic [3:0] ST_NUM_BAD   = 4'd6;
  localparam logic [3:0] ST_MISSING   = 4'd7;
  localparam logic [3:0] ST_SIZE      = 4'd8;

  localparam logic [1:0] CFG_MAX_RECORD_BYTES   = 2'd0;
  localparam logic [1:0] CFG_DESCRIPTION_LENGTH = 2'd1;

  localparam logic [15:0] MAX_RECORD_RESET = 16'd4096;
  localparam logic [12:0] DESC_LEN_RESET   = 13'd44;

  localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
  localparam logic [3:0]  VARINT_LAST_IDX = 4'd9;
  localparam logic [3:0]  FIELD_DESC      = 4'd2;
  localparam logic [3:0]  FIELD_LAST      = 4'd8;
  localparam logic [2:0]  WIRE_VARINT     = 3'd0;
  localparam logic [2:0]  WIRE_LEN_DELIM  = 3'd2;
  localparam int          NUM_VALUES      = 7;

endpackage

`default_nettype wire

/* sv/vrfp_fifo.sv */
// ----------------------------------------------------------------------------
// vrfp_fifo
// short register queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module vrfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/vrfp_front.sv */
// ----------------------------------------------------------------------------
// vrfp_front
// takes request bytes, counts the record length and flags oversize records
// ----------------------------------------------------------------------------
`default_nettype none

module vrfp_front
  import vrfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire vrfp_in_t    in_data,
  output logic             in_full,
  input  wire logic [15:0] max_record_bytes,
  input  wire logic        q_full,
  output logic             q_push,
  output vrfp_mid_t        q_wdata
);

  logic [16:0] count_r, count_nxt;
  logic [16:0] count_inc;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // saturating byte count including this byte
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 17'd1;

  always_comb begin
    q_wdata.req      = in_data;
    q_wdata.size_bad = (count_inc > {1'b0, max_record_bytes});
    count_nxt        = count_r;
    if (q_push) begin
      count_nxt = in_data.last_byte ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/vrfp_back.sv */
// ----------------------------------------------------------------------------
// vrfp_back
// varint and key parser, field store and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "varint_record_field_parser_assert.svh"

module vrfp_back
  import vrfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [12:0] description_length,
  input  wire logic        q_empty,
  input  wire vrfp_mid_t   q_rdata,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output vrfp_out_t        out_data
);

  vrfp_phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  cur_r, cur_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [12:0] skip_r, skip_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [63:0] val_r [NUM_VALUES];
  logic [63:0] val_nxt [NUM_VALUES];
  logic        out_valid_r, out_valid_nxt;
  vrfp_out_t   out_data_r, out_data_nxt;

  logic        fire, is_last, out_taken;
  logic [6:0]  payload;
  logic        cont;
  logic [6:0]  shamt;
  logic [63:0] acc_new;
  logic        feed_bad;
  logic [3:0]  key_fld;
  logic        key_fld_ok;
  logic [2:0]  key_wire;
  logic [3:0]  status;

  assign is_last   = q_rdata.req.last_byte;
  assign out_taken = out_pop && out_valid_r;
  assign q_pop     = !q_empty && (!is_last || !out_valid_r || out_taken);
  assign fire      = q_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  assign payload  = q_rdata.req.data_byte[6:0];
  assign cont     = q_rdata.req.data_byte[7];
  assign shamt    = 7'(idx_r) * 7'd7;
  assign acc_new  = acc_r | (64'(payload) << shamt);
  assign feed_bad = (idx_r > VARINT_LAST_IDX)
                 || ((idx_r == VARINT_LAST_IDX) && ((payload > 7'd1) || cont))
                 || (!cont && (idx_r != '0) && (payload == '0));

  assign key_fld    = acc_new[6:3];
  assign key_fld_ok = (acc_new[63:7] == '0) && (key_fld != '0) && (key_fld <= FIELD_LAST);
  assign key_wire   = acc_new[2:0];

  always_comb begin
    logic       done;
    logic [2:0] slot;
    done      = 1'b0;
    slot      = (cur_r == 4'd1) ? 3'd0 : 3'(cur_r - 4'd2);
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    seen_nxt  = seen_r;
    skip_nxt  = skip_r;
    err_nxt   = err_r;
    for (int k = 0; k < NUM_VALUES; k++) begin
      val_nxt[k] = val_r[k];
    end
    status        = ST_OK;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_taken;

    if (fire && (err_r == ST_OK)) begin
      if (phase_r == PH_SKIP) begin
        skip_nxt = (skip_r != '0) ? skip_r - 13'd1 : skip_r;
        done     = (skip_nxt == '0);
      end else if (feed_bad) begin
        case (phase_r)
          PH_KEY:   err_nxt = ST_KEY_BAD;
          PH_VALUE: err_nxt = ST_NUM_BAD;
          default:  err_nxt = ST_DESC_LEN;
        endcase
      end else begin
        acc_nxt = acc_new;
        idx_nxt = cont ? idx_r + 4'd1 : '0;
        if (!cont) begin
          case (phase_r)
            PH_KEY: begin
              acc_nxt = '0;
              if (acc_new == '0) begin
                err_nxt = ST_KEY_BAD;
              end else if (!key_fld_ok || seen_r[3'(key_fld - 4'd1)]) begin
                err_nxt = ST_FIELD_BAD;
              end else begin
                cur_nxt = key_fld;
                if (key_fld == FIELD_DESC) begin
                  if (key_wire != WIRE_LEN_DELIM) err_nxt = ST_DESC_WIRE;
                  else phase_nxt = PH_LENGTH;
                end else begin
                  if (key_wire != WIRE_VARINT) err_nxt = ST_NUM_WIRE;
                  else phase_nxt = PH_VALUE;
                end
              end
            end
            PH_VALUE: begin
              val_nxt[slot] = acc_new;
              done          = 1'b1;
            end
            default: begin
              acc_nxt = '0;
              if (acc_new != 64'(description_length)) begin
                err_nxt = ST_DESC_LEN;
              end else if (description_length == '0) begin
                done = 1'b1;
              end else begin
                skip_nxt  = description_length;
                phase_nxt = PH_SKIP;
              end
            end
          endcase
        end
      end
      if (done) begin
        seen_nxt[3'(cur_r - 4'd1)] = 1'b1;
        phase_nxt                  = PH_KEY;
        acc_nxt                    = '0;
      end
    end

    if (fire && is_last) begin
      if (q_rdata.size_bad) status = ST_SIZE;
      else if (err_nxt != ST_OK) status = err_nxt;
      else if ((phase_nxt == PH_KEY) && (idx_nxt != '0)) status = ST_KEY_BAD;
      else if (phase_nxt == PH_VALUE) status = ST_NUM_BAD;
      else if (phase_nxt != PH_KEY) status = ST_DESC_LEN;
      else if (seen_nxt != 8'hFF) status = ST_MISSING;
      else status = ST_OK;

      out_data_nxt.status            = status;
      out_data_nxt.magic             = (status == ST_OK) ? val_nxt[0] : '0;
      out_data_nxt.kind              = (status == ST_OK) ? val_nxt[1] : '0;
      out_data_nxt.header_version    = (status == ST_OK) ? val_nxt[2] : '0;
      out_data_nxt.frames_per_second = (status == ST_OK) ? val_nxt[3] : '0;
      out_data_nxt.frame_width       = (status == ST_OK) ? val_nxt[4] : '0;
      out_data_nxt.frame_height      = (status == ST_OK) ? val_nxt[5] : '0;
      out_data_nxt.frame_count       = (status == ST_OK) ? val_nxt[6] : '0;
      out_valid_nxt                  = 1'b1;

      // back to the start of a record
      phase_nxt = PH_KEY;
      acc_nxt   = '0;
      idx_nxt   = '0;
      cur_nxt   = '0;
      seen_nxt  = '0;
      skip_nxt  = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      acc_r       <= '0;
      idx_r       <= '0;
      cur_r       <= '0;
      seen_r      <= '0;
      skip_r      <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      seen_r      <= seen_nxt;
      skip_r      <= skip_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    for (int k = 0; k < NUM_VALUES; k++) begin
      val_r[k] <= val_nxt[k];
    end
  end

  `VRFP_ASSERT_IMP(a_skip_nonzero, phase_r == PH_SKIP, skip_r != '0)
  `VRFP_ASSERT_IMP(a_idx_range, 1'b1, idx_r <= VARINT_LAST_IDX)
  `VRFP_ASSERT_NXT(a_err_sticky, (err_r != ST_OK) && !(fire && is_last), err_r == $past(err_r))
  `VRFP_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_taken, !(fire && is_last))

endmodule

`default_nettype wire

/* sv/varint_record_field_parser.sv */
// ----------------------------------------------------------------------------
// varint_record_field_parser
// streaming parser for a key/varint metadata record, one result per record
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   in_       request    in_push / in_full   vrfp_in_t  (data_byte, last_byte)
//   out_      result     out_pop / out_empty vrfp_out_t (status, seven values)
//   cfg_      write      cfg_we              cfg_index, cfg_wdata
//
// one byte per cycle unless a last byte stalls behind an unread result; each
// byte is registered in the front queue, each result in the output register
// the parser step (varint shift-or, key check, field store) sets the cycle time
// rst_n is synchronous, active low; it restores register defaults 4096 and 44
// a finished result waits in the output register; only the next last byte
// stalls behind it, ordinary bytes ahead of that byte keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module varint_record_field_parser
  import vrfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request bytes
  input  wire logic        in_push,
  input  wire vrfp_in_t    in_data,
  output logic             in_full,
  // record results
  output logic             out_empty,
  input  wire logic        out_pop,
  output vrfp_out_t        out_data,
  // register writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration registers
  logic [15:0] max_record_bytes_r, max_record_bytes_nxt;
  logic [12:0] desc_len_r, desc_len_nxt;

  // front to back queue
  logic      q_full, q_push, q_pop, q_empty;
  vrfp_mid_t q_wdata, q_rdata;

  // writes to indexes beyond the list are dropped
  always_comb begin
    max_record_bytes_nxt = max_record_bytes_r;
    desc_len_nxt         = desc_len_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_RECORD_BYTES:   max_record_bytes_nxt = cfg_wdata;
        CFG_DESCRIPTION_LENGTH: desc_len_nxt         = cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_record_bytes_r <= MAX_RECORD_RESET;
      desc_len_r         <= DESC_LEN_RESET;
    end else begin
      max_record_bytes_r <= max_record_bytes_nxt;
      desc_len_r         <= desc_len_nxt;
    end
  end

  // front: byte counting and size classification
  vrfp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data          (in_data),
    .in_full          (in_full),
    .max_record_bytes (max_record_bytes_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  // decoupling queue, lets the parser stall on the result side on its own
  vrfp_fifo #(
    .WIDTH ($bits(vrfp_mid_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: varint parsing, field checks and result register
  vrfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .description_length (desc_len_r),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_data           (out_data)
  );

endmodule

`default_nettype wire

/* verif/varint_record_field_parser_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varint_record_field_parser_checker
// watches the request, result and register ports of the record parser, keeps
// its own copy of the parse state and compares every result field by field
// ----------------------------------------------------------------------------

module varint_record_field_parser_checker
  import vrfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire vrfp_in_t    in_data,
  input  wire logic        in_full,
  input  wire logic        out_empty,
  input  wire logic        out_pop,
  input  wire vrfp_out_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               records_in_flight,
  output int               mismatch_total
);

  localparam logic [3:0] FIELD_MAGIC = 4'd1;

  typedef enum {VI_MORE, VI_DONE, VI_BAD} varint_step_t;

  // register copies
  logic [15:0] max_bytes;
  logic [12:0] desc_len;

  // parse state
  vrfp_phase_t phase;
  logic [63:0] acc;
  logic [3:0]  vlen;
  logic [3:0]  cur_field;
  logic [7:0]  seen;
  logic [63:0] field_store [NUM_VALUES];
  logic [12:0] skip_left;
  logic [16:0] byte_count;
  logic [3:0]  err;

  vrfp_out_t expected_records [$];
  int        mismatches = 0;
  int        results_seen = 0;

  function automatic void clear_record();
    phase      = PH_KEY;
    acc        = '0;
    vlen       = '0;
    cur_field  = '0;
    seen       = '0;
    foreach (field_store[k]) field_store[k] = '0;
    skip_left  = '0;
    byte_count = '0;
    err        = ST_OK;
  endfunction

  function automatic varint_step_t take_varint_byte(input logic [7:0] b);
    logic [3:0] i;
    i = vlen;
    if (i > VARINT_LAST_IDX) return VI_BAD;
    if (i == VARINT_LAST_IDX && b[6:0] > 7'd1) return VI_BAD;
    acc = acc | (64'(b[6:0]) << (7 * i));
    if (!b[7]) begin
      vlen = '0;
      // a zero closing byte after the first means a padded encoding
      return (i != 0 && b[6:0] == 7'd0) ? VI_BAD : VI_DONE;
    end
    if (i == VARINT_LAST_IDX) return VI_BAD;
    vlen = i + 4'd1;
    return VI_MORE;
  endfunction

  function automatic void close_field();
    seen[3'(cur_field - 4'd1)] = 1'b1;
    phase = PH_KEY;
    acc   = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    varint_step_t r;
    logic [63:0]  fld;
    logic [63:0]  len;
    logic [2:0]   wt;
    int           slot;
    if (phase == PH_SKIP) begin
      if (skip_left != 0) skip_left = skip_left - 13'd1;
      if (skip_left == 0) close_field();
      return;
    end
    r = take_varint_byte(b);
    if (r == VI_BAD) begin
      err = (phase == PH_KEY) ? ST_KEY_BAD : (phase == PH_VALUE) ? ST_NUM_BAD : ST_DESC_LEN;
      return;
    end
    if (r == VI_MORE) return;
    case (phase)
      PH_KEY: begin
        fld = acc >> 3;
        wt  = acc[2:0];
        if (acc == 0) begin
          acc = '0;
          err = ST_KEY_BAD;
          return;
        end
        acc = '0;
        if (fld < 1 || fld > FIELD_LAST || seen[3'(fld - 1)]) begin
          err = ST_FIELD_BAD;
          return;
        end
        cur_field = fld[3:0];
        if (fld == FIELD_DESC) begin
          if (wt != WIRE_LEN_DELIM) err = ST_DESC_WIRE;
          else phase = PH_LENGTH;
        end else begin
          if (wt != WIRE_VARINT) err = ST_NUM_WIRE;
          else phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        slot = (cur_field == FIELD_MAGIC) ? 0 : int'(cur_field) - int'(FIELD_DESC);
        field_store[slot] = acc;
        close_field();
      end
      default: begin
        len = acc;
        acc = '0;
        if (len != 64'(desc_len)) err = ST_DESC_LEN;
        else if (len == 0) close_field();
        else begin
          skip_left = len[12:0];
          phase     = PH_SKIP;
        end
      end
    endcase
  endfunction

  function automatic void predict_byte(input vrfp_in_t req);
    vrfp_out_t  res;
    logic [3:0] st;
    if (byte_count != COUNT_MAX) byte_count = byte_count + 17'd1;
    if (err == ST_OK) parse_byte(req.data_byte);
    if (!req.last_byte) return;
    if (byte_count > 17'(max_bytes)) st = ST_SIZE;
    else if (err != ST_OK) st = err;
    else if (phase == PH_KEY && vlen != 0) st = ST_KEY_BAD;
    else if (phase == PH_VALUE) st = ST_NUM_BAD;
    else if (phase != PH_KEY) st = ST_DESC_LEN;
    else if (seen != 8'hFF) st = ST_MISSING;
    else st = ST_OK;
    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.magic             = field_store[0];
      res.kind              = field_store[1];
      res.header_version    = field_store[2];
      res.frames_per_second = field_store[3];
      res.frame_width       = field_store[4];
      res.frame_height      = field_store[5];
      res.frame_count       = field_store[6];
    end
    expected_records.push_back(res);
    clear_record();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
  endtask

  task automatic check_result(input vrfp_out_t got);
    vrfp_out_t want;
    results_seen++;
    if (expected_records.size() == 0) begin
      report_mismatch("unrequested result, status", 64'(got.status), '0);
      return;
    end
    want = expected_records.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.magic !== want.magic) report_mismatch("magic", got.magic, want.magic);
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.header_version !== want.header_version)
      report_mismatch("header_version", got.header_version, want.header_version);
    if (got.frames_per_second !== want.frames_per_second)
      report_mismatch("frames_per_second", got.frames_per_second, want.frames_per_second);
    if (got.frame_width !== want.frame_width)
      report_mismatch("frame_width", got.frame_width, want.frame_width);
    if (got.frame_height !== want.frame_height)
      report_mismatch("frame_height", got.frame_height, want.frame_height);
    if (got.frame_count !== want.frame_count)
      report_mismatch("frame_count", got.frame_count, want.frame_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_bytes = MAX_RECORD_RESET;
      desc_len  = DESC_LEN_RESET;
      clear_record();
      expected_records.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_RECORD_BYTES:   max_bytes = cfg_wdata;
          CFG_DESCRIPTION_LENGTH: desc_len  = cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_byte(in_data);
      if (out_pop && !out_empty) check_result(out_data);
    end
    records_in_flight <= expected_records.size();
    mismatch_total    <= mismatches;
  end

endmodule

/* verif/varint_record_field_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varint_record_field_parser_tb
// drives metadata records byte by byte into the record parser: well-formed
// records with random field order and values, every kind of broken record,
// size limits and register settings at their extremes, under several idling
// patterns; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------

module varint_record_field_parser_tb
  import vrfp_pkg::*;
();

  localparam int         CYCLE_LIMIT      = 2_000_000;
  localparam int         LONG_HOLD        = 400;  // receiver hold-off in cycles
  localparam int         SETTLE_CYCLES    = 4;    // front queue plus parser stage, with slack
  localparam int         END_CYCLES       = 20;
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  // how a generated record is shaped; everything but good is broken on purpose
  typedef enum int {
    REC_GOOD,
    REC_TRUNCATE,
    REC_MISSING,
    REC_DUPLICATE,
    REC_UNKNOWN_FIELD,
    REC_ZERO_KEY,
    REC_BAD_KEY_VARINT,
    REC_DESC_WIRE,
    REC_NUM_WIRE,
    REC_DESC_LEN,
    REC_NONCANON_VALUE,
    REC_TENTH_PAYLOAD,
    REC_TENTH_CONT,
    REC_NOISE
  } record_shape_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  vrfp_in_t    in_data   = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  vrfp_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int   records_in_flight;
  int   mismatch_total;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;   // only the stimulus process reads this one
  int   recv_stall_pct = 0;   // read by the receiver process, so written with <=
  logic hold_req       = 1'b0;
  int   hold_left      = 0;

  // bytes of the record being built, and the description length it must carry
  logic [7:0]  rec_bytes [$];
  logic [12:0] desc_len_now = DESC_LEN_RESET;

  varint_record_field_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  varint_record_field_parser_checker field_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_data           (in_data),
    .in_full           (in_full),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data          (out_data),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .records_in_flight (records_in_flight),
    .mismatch_total    (mismatch_total)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("varint_record_field_parser_tb: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked for, counted here
  always @(posedge clk) begin
    if (hold_req) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // values skewed toward short encodings, with all ones now and then
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          nbits;
    v     = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
    if ($urandom_range(0, 15) == 0) v = '1;
    return v;
  endfunction

  // canonical little-endian base-128 encoding
  function automatic void put_varint(input logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      rec_bytes.push_back(b);
    end while (v != 0);
  endfunction

  function automatic void put_key(input logic [63:0] fld, input logic [2:0] wire_type);
    put_varint((fld << 3) | 64'(wire_type));
  endfunction

  // one key and its value; when this field is the target, the shape's flaw goes in here
  function automatic void put_field(input int fld, input record_shape_t shape, input bit target);
    logic [2:0]  wt;
    logic [63:0] len;
    logic [63:0] bad_fld;
    wt = (fld == FIELD_DESC) ? WIRE_LEN_DELIM : WIRE_VARINT;
    if (target) begin
      case (shape)
        REC_MISSING: return;
        REC_ZERO_KEY: rec_bytes.push_back(8'h00);
        REC_BAD_KEY_VARINT: begin
          // padded key: continuation set, then an empty closing byte
          rec_bytes.push_back(8'h80 | 8'((fld << 3) | wt));
          rec_bytes.push_back(8'h00);
          return;
        end
        REC_UNKNOWN_FIELD: begin
          if ($urandom_range(0, 3) == 0) begin
            // field number zero with a nonzero wire type
            put_key(64'd0, 3'($urandom_range(1, 7)));
          end else begin
            bad_fld = $urandom_range(FIELD_LAST + 1, 1 << 20);
            put_key(bad_fld, 3'($urandom));
          end
          return;
        end
        REC_DESC_WIRE, REC_NUM_WIRE: wt = wt ^ 3'($urandom_range(1, 7));
        default: ;
      endcase
    end
    put_key(64'(fld), wt);
    if (fld == FIELD_DESC) begin
      len = 64'(desc_len_now);
      if (target && shape == REC_DESC_LEN) len = len ^ (64'd1 << $urandom_range(0, 63));
      put_varint(len);
      repeat (desc_len_now) rec_bytes.push_back(8'($urandom));
    end else if (target && shape == REC_NONCANON_VALUE) begin
      put_varint(random_value() >> 8);
      rec_bytes[rec_bytes.size() - 1][7] = 1'b1;
      rec_bytes.push_back(8'h00);
    end else if (target && (shape == REC_TENTH_PAYLOAD || shape == REC_TENTH_CONT)) begin
      repeat (9) rec_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
      if (shape == REC_TENTH_PAYLOAD) rec_bytes.push_back(8'($urandom_range(2, 127)));
      else rec_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end else begin
      put_varint(random_value());
    end
  endfunction

  function automatic void build_record(input record_shape_t shape);
    int field_order [8];
    int j;
    int tmp;
    int tf;
    rec_bytes.delete();
    if (shape == REC_NOISE) begin
      repeat ($urandom_range(1, 12)) rec_bytes.push_back(8'($urandom));
      return;
    end
    // fields may come in any order
    for (int i = 0; i < FIELD_LAST; i++) field_order[i] = i + 1;
    for (int i = FIELD_LAST - 1; i > 0; i--) begin
      j              = $urandom_range(0, i);
      tmp            = field_order[i];
      field_order[i] = field_order[j];
      field_order[j] = tmp;
    end
    // pick the field that carries the flaw
    case (shape)
      REC_DESC_WIRE, REC_DESC_LEN: tf = FIELD_DESC;
      REC_NUM_WIRE, REC_NONCANON_VALUE, REC_TENTH_PAYLOAD, REC_TENTH_CONT: begin
        tf = $urandom_range(1, FIELD_LAST - 1);
        if (tf >= FIELD_DESC) tf++;
      end
      default: tf = $urandom_range(1, FIELD_LAST);
    endcase
    foreach (field_order[i]) begin
      put_field(field_order[i], shape, field_order[i] == tf);
      if (shape == REC_DUPLICATE && field_order[i] == tf) put_field(tf, REC_GOOD, 1'b0);
    end
    if (shape == REC_TRUNCATE && rec_bytes.size() > 1)
      rec_bytes = rec_bytes[0 : $urandom_range(0, rec_bytes.size() - 2)];
    // bytes after an error are only counted, never parsed
    if (shape != REC_GOOD && shape != REC_TRUNCATE && $urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom));
  endfunction

  // mostly well-formed records, some truncated, the rest broken or noise
  function automatic record_shape_t pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return REC_GOOD;
    if (r < 65) return REC_TRUNCATE;
    if (r < 70) return REC_NOISE;
    return record_shape_t'($urandom_range(REC_MISSING, REC_TENTH_CONT));
  endfunction

  // push stays high from one request to the next unless an idle cycle comes between
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_record();
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  // sender pauses until every expected result is out, then lets the pipeline settle
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (records_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 87;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 87;
      end
      default: begin
        send_idle_pct = 20;
        recv_stall_pct <= 20;
      end
    endcase
  endtask

  // one register setting, one idling pattern, records until the byte budget is spent
  task automatic run_phase(input logic [15:0] desc_w, input logic [15:0] max_w,
                           input idle_mode_t mode, input int budget, input bit pressure);
    int sent;
    write_reg(CFG_DESCRIPTION_LENGTH, desc_w);
    desc_len_now = desc_w[12:0];
    write_reg(CFG_MAX_RECORD_BYTES, max_w);
    set_idling(mode);
    if (pressure) begin
      // receiver holds off while short records keep coming, so the input backs up
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
    sent = 0;
    while (sent < budget) begin
      if (pressure) begin
        rec_bytes.delete();
        repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
      end else begin
        build_record(pick_shape());
      end
      send_record();
      sent += rec_bytes.size();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults straight out of reset
    build_record(REC_GOOD);
    send_record();

    // a write to an index past the register list must leave both registers alone
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    build_record(REC_GOOD);
    send_record();

    // every record shape once, short description so truncation can land in the skip
    write_reg(CFG_DESCRIPTION_LENGTH, 16'd2);
    desc_len_now = 13'd2;
    write_reg(CFG_MAX_RECORD_BYTES, 16'hFFFF);
    for (int k = REC_GOOD; k <= REC_NOISE; k++) begin
      build_record(record_shape_t'(k));
      send_record();
    end
    build_record(REC_TRUNCATE);
    send_record();

    // random part
    run_phase(16'd3, 16'hFFFF, IDLE_NONE, 90, 1'b0);
    run_phase(16'd0, MAX_RECORD_RESET, IDLE_SENDER, 90, 1'b0);
    run_phase(16'd9, 16'd40, IDLE_RECEIVER, 90, 1'b0);         // size limit bites often
    run_phase(16'hE005, 16'd0, IDLE_BOTH, 50, 1'b0);           // masked write, zero limit
    run_phase(16'd1, 16'd1, IDLE_NONE, 50, 1'b0);              // one byte allowed
    run_phase(16'($urandom_range(0, 20)), 16'($urandom_range(20, 120)), IDLE_RECEIVER,
              90, 1'b0);
    run_phase(16'($urandom_range(0, 20)), 16'hFFFF, IDLE_BOTH, 90, 1'b0);
    run_phase(16'd6, 16'($urandom_range(1, 65535)), IDLE_SENDER, 90, 1'b0);
    run_phase(16'd2, 16'hFFFF, IDLE_NONE, 60, 1'b1);           // long receiver hold-off
    run_phase(16'($urandom_range(0, 20)), 16'hFFFF, IDLE_NONE, 50, 1'b0);

    // description length 4096, record cut off early in the skip
    write_reg(CFG_DESCRIPTION_LENGTH, 16'd4096);
    desc_len_now = 13'd4096;
    set_idling(IDLE_NONE);
    build_record(REC_GOOD);
    rec_bytes = rec_bytes[0 : 99];
    send_record();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("varint_record_field_parser_tb: clean");
    end else begin
      $display("varint_record_field_parser_tb: errors");
    end
    $finish;
  end

endmodule
